>>> hw/rtl/velocity_command_safety_filter_core_assert.svh
// assertion macros shared by the safety filter rtl
`ifndef VELOCITY_COMMAND_SAFETY_FILTER_CORE_ASSERT_SVH
`define VELOCITY_COMMAND_SAFETY_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// checked on clk_i, masked while rst_ni is low
`define VCSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vcsf assertion failed");

// checked on clk_i, reset included
`define VCSF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("vcsf reset assertion failed");

`else

`define VCSF_ASSERT(lbl, prop)
`define VCSF_ASSERT_RST(lbl, prop)

`endif

`endif

>>> hw/rtl/vcsf_pkg.sv
package vcsf_pkg;

  localparam int unsigned VelW   = 16;
  localparam int unsigned LimW   = 15;
  localparam int unsigned AltW   = 24;
  localparam int unsigned FloorW = 23;
  localparam int unsigned CfgW   = 23;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LimW-1:0]   MaxLinearRst   = 15'd12288;
  localparam logic [LimW-1:0]   MaxAngularRst  = 15'd3277;
  localparam logic [LimW-1:0]   RampRateRst    = 15'd6144;
  localparam logic [FloorW-1:0] MinAltitudeRst = 23'd2048;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_LINEAR   = 2'd0,
    REG_MAX_ANGULAR  = 2'd1,
    REG_RAMP_RATE    = 2'd2,
    REG_MIN_ALTITUDE = 2'd3
  } vcsf_reg_e;

  typedef struct packed {
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] vel_z;
    logic signed [VelW-1:0] rate_pitch;
    logic signed [VelW-1:0] rate_yaw;
    logic                   healthy;
    logic                   pose_fresh;
    logic signed [AltW-1:0] altitude;
  } vcsf_req_t;

  typedef struct packed {
    logic signed [VelW-1:0] out_x;
    logic signed [VelW-1:0] out_y;
    logic signed [VelW-1:0] out_z;
    logic signed [VelW-1:0] out_pitch;
    logic signed [VelW-1:0] out_yaw;
  } vcsf_res_t;

  typedef struct packed {
    logic [LimW-1:0]   lin_limit;
    logic [LimW-1:0]   ang_limit;
    logic [LimW-1:0]   ramp_rate;
    logic [FloorW-1:0] min_altitude;
  } vcsf_cfg_t;

endpackage

>>> hw/rtl/vcsf_cfg.sv
module vcsf_cfg
  import vcsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output vcsf_cfg_t          cfg_o
);

  vcsf_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (vcsf_reg_e'(cfg_idx_i))
        REG_MAX_LINEAR:   cfg_d.lin_limit    = cfg_data_i[LimW-1:0];
        REG_MAX_ANGULAR:  cfg_d.ang_limit    = cfg_data_i[LimW-1:0];
        REG_RAMP_RATE:    cfg_d.ramp_rate    = cfg_data_i[LimW-1:0];
        REG_MIN_ALTITUDE: cfg_d.min_altitude = cfg_data_i[FloorW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lin_limit    <= MaxLinearRst;
      cfg_q.ang_limit    <= MaxAngularRst;
      cfg_q.ramp_rate    <= RampRateRst;
      cfg_q.min_altitude <= MinAltitudeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/vcsf_axis.sv
module vcsf_axis
  import vcsf_pkg::*;
(
  input  logic signed [VelW-1:0] cmd_i,
  input  logic signed [VelW-1:0] prev_i,
  input  logic [LimW-1:0]        limit_i,
  input  logic [LimW-1:0]        rate_i,
  input  logic                   block_neg_i,
  output logic signed [VelW-1:0] val_o
);

  // two guard bits: the difference of two 16 bit values needs 17, plus sign room
  localparam int unsigned ExtW = VelW + 2;

  logic signed [ExtW-1:0] cmd_ext, prev_ext, lim_ext, rate_ext;
  logic signed [ExtW-1:0] clamp, diff, stepped;

  always_comb begin
    cmd_ext  = ExtW'(cmd_i);
    prev_ext = ExtW'(prev_i);
    lim_ext  = $signed({{(ExtW-LimW){1'b0}}, limit_i});
    rate_ext = $signed({{(ExtW-LimW){1'b0}}, rate_i});

    if (cmd_ext > lim_ext) begin
      clamp = lim_ext;
    end else if (cmd_ext < -lim_ext) begin
      clamp = -lim_ext;
    end else begin
      clamp = cmd_ext;
    end

    // descent blocked near the floor
    if (block_neg_i && clamp < 0) begin
      clamp = '0;
    end

    diff = clamp - prev_ext;
    if (diff > rate_ext) begin
      stepped = prev_ext + rate_ext;
    end else if (diff < -rate_ext) begin
      stepped = prev_ext - rate_ext;
    end else begin
      stepped = clamp;
    end
  end

  // result lies between prev and the clamped command, so it fits
  assign val_o = stepped[VelW-1:0];

endmodule

>>> hw/rtl/velocity_command_safety_filter_core.sv
// Velocity command safety filter: magnitude clamp, descent floor and slew limit
// on a five-axis velocity command (x, y, z velocity, pitch and yaw rate).
// Request channel: in_valid_i / in_ready_o with in_req_i (command, health,
// pose freshness, altitude). Result channel: out_valid_o / out_ready_i with
// out_res_o, exactly one result per request, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at a clock
// edge (0 linear limit, 1 angular limit, 2 ramp rate, 3 altitude floor); write
// only while no request is in flight.
// A request passes the input register, then the result register. Throughput:
// one request per cycle while the receiver does not stall, since the clamp and
// slew of all five axes sit in one stage between the two registers and the
// result register doubles as the previous-output store.
// Reset clears both stages, the previous output to zero and the registers to
// their defaults. When the receiver stalls the result holds; one more request
// is taken into the input register, after which in_ready_o drops.
module velocity_command_safety_filter_core
  import vcsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vcsf_req_t          in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vcsf_res_t          out_res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  `include "velocity_command_safety_filter_core_assert.svh"

  vcsf_cfg_t cfg;

  logic      s1_valid_q, s1_valid_d;
  vcsf_req_t s1_req_q;
  logic      out_valid_q, out_valid_d;
  vcsf_res_t out_q, out_d;
  vcsf_res_t axis_res;
  logic      out_load, in_acc, floor_hit;

  vcsf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_acc     = in_valid_i && in_ready_o;

  assign floor_hit = s1_req_q.pose_fresh &&
                     ($signed(s1_req_q.altitude) < $signed({1'b0, cfg.min_altitude}));

  vcsf_axis u_axis_x (
    .cmd_i (s1_req_q.vel_x), .prev_i (out_q.out_x), .limit_i (cfg.lin_limit),
    .rate_i (cfg.ramp_rate), .block_neg_i (1'b0), .val_o (axis_res.out_x)
  );
  vcsf_axis u_axis_y (
    .cmd_i (s1_req_q.vel_y), .prev_i (out_q.out_y), .limit_i (cfg.lin_limit),
    .rate_i (cfg.ramp_rate), .block_neg_i (1'b0), .val_o (axis_res.out_y)
  );
  vcsf_axis u_axis_z (
    .cmd_i (s1_req_q.vel_z), .prev_i (out_q.out_z), .limit_i (cfg.lin_limit),
    .rate_i (cfg.ramp_rate), .block_neg_i (floor_hit), .val_o (axis_res.out_z)
  );
  vcsf_axis u_axis_pitch (
    .cmd_i (s1_req_q.rate_pitch), .prev_i (out_q.out_pitch), .limit_i (cfg.ang_limit),
    .rate_i (cfg.ramp_rate), .block_neg_i (1'b0), .val_o (axis_res.out_pitch)
  );
  vcsf_axis u_axis_yaw (
    .cmd_i (s1_req_q.rate_yaw), .prev_i (out_q.out_yaw), .limit_i (cfg.ang_limit),
    .rate_i (cfg.ramp_rate), .block_neg_i (1'b0), .val_o (axis_res.out_yaw)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      // unhealthy forces the result to zero, bypassing clamp and slew
      out_d       = s1_req_q.healthy ? axis_res : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q <= in_req_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `VCSF_ASSERT(a_unhealthy_zero, (out_load && !s1_req_q.healthy) |=> (out_q == '0))
  `VCSF_ASSERT(a_ready_low_full, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
  `VCSF_ASSERT(a_zero_rate_holds,
               (out_load && s1_req_q.healthy && cfg.ramp_rate == '0) |=> $stable(out_q))
  `VCSF_ASSERT_RST(a_reset_empty, !rst_ni |-> (!out_valid_o && in_ready_o))

endmodule
